// File: rtl/core/crde_pkg.sv
// Shared types and constants for the clipped raster draw engine.
package crde_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 7;
    localparam int CRD_W      = 18;
    localparam int STP_W      = 17;
    localparam logic [31:0] RESET_PIXEL = 32'h0000_00FF;

    typedef logic signed [CRD_W-1:0] t_crd;

    typedef enum logic [1:0] {
        OP_FILL    = 2'd0,
        OP_OUTLINE = 2'd1,
        OP_LINE    = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SETUP1, S_SETUP2, S_RECT, S_LINE, S_READ, S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic setup1;
        logic setup2;
        logic clr_step;
        logic rect_step;
        logic line_step;
        logic rd;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic clr_last;
        logic rect_empty;
        logic rect_last;
        logic line_empty;
        logic line_last;
    } t_sts;

endpackage

// File: rtl/core/crde_ctrl.sv
// Command sequencer for the raster draw engine.
module crde_ctrl import crde_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy,
    output logic o_done
);

    t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:   if (start) n_state = S_SETUP1;
            S_SETUP1: n_state = (i_sts.op == OP_READ) ? S_READ : S_SETUP2;
            S_SETUP2: n_state = (i_sts.op == OP_LINE) ? S_LINE : S_RECT;
            S_RECT:   if (i_sts.rect_empty || i_sts.rect_last) n_state = S_DONE;
            S_LINE:   if (i_sts.line_empty || i_sts.line_last) n_state = S_DONE;
            S_READ:   n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && start;
        o_cmd.setup1    = (r_state == S_SETUP1);
        o_cmd.setup2    = (r_state == S_SETUP2);
        o_cmd.clr_step  = (r_state == S_CLEAR);
        o_cmd.rect_step = (r_state == S_RECT);
        o_cmd.line_step = (r_state == S_LINE);
        o_cmd.rd        = (r_state == S_READ);
        busy            = (r_state != S_IDLE);
        o_done          = (r_state == S_DONE);
    end

endmodule

// File: rtl/core/crde_dp.sv
// Datapath of the raster draw engine: walkers, clipping and frame store.
module crde_dp import crde_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [DIM_W-1:0]   i_w,
    input  logic [DIM_W-1:0]   i_h,
    input  logic [1:0]         i_opcode,
    input  logic [31:0]        i_color,
    input  logic signed [15:0] i_ax,
    input  logic signed [15:0] i_ay,
    input  logic signed [15:0] i_bx,
    input  logic signed [15:0] i_by,
    output t_sts               o_sts,
    output logic [31:0]        o_pixel_value,
    output logic               o_read_outside
);

    logic [31:0] mem [MAX_WIDTH*MAX_HEIGHT];

    t_op              r_op;
    logic [31:0]      r_color;
    t_crd             r_ax, r_ay, r_bx, r_by;
    t_crd             r_sumx, r_sumy, r_dx, r_dy;
    t_crd             r_rx0, r_rxl, r_ryl, r_ex, r_ey, r_cx, r_cy;
    logic             r_rect_empty;
    t_crd             r_lx, r_ly;
    logic [STP_W-1:0] r_adx, r_ady, r_steps, r_stm1, r_i, r_accx, r_accy;
    logic             r_sx, r_sy;
    logic [ADDR_W-1:0] r_clr;
    logic [31:0]      r_rdata;
    logic             r_outside;

    t_crd             wd, hd, rx0, rx1, ry0, ry1, adx, ady;
    logic [STP_W:0]   sumax, sumay;
    t_crd             px, py;
    logic             in_frame, border, we;
    logic [XW+DIM_W:0] prod;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [31:0]      wdata;
    logic             rd_out;

    assign wd = t_crd'(i_w > DIM_W'(MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : i_w);
    assign hd = t_crd'(i_h > DIM_W'(MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : i_h);

    // Clip the rectangle and take line magnitudes
    always_comb begin
        rx0 = (r_ax < 0) ? '0 : r_ax;
        ry0 = (r_ay < 0) ? '0 : r_ay;
        rx1 = (r_sumx > wd) ? wd : r_sumx;
        ry1 = (r_sumy > hd) ? hd : r_sumy;
        adx = (r_dx < 0) ? -r_dx : r_dx;
        ady = (r_dy < 0) ? -r_dy : r_dy;
    end

    assign sumax = {1'b0, r_accx} + {1'b0, r_adx};
    assign sumay = {1'b0, r_accy} + {1'b0, r_ady};

    // Current plot point and clip test
    always_comb begin
        px       = i_cmd.line_step ? r_lx : r_cx;
        py       = i_cmd.line_step ? r_ly : r_cy;
        in_frame = (px >= 0) && (py >= 0) && (px < wd) && (py < hd);
        border   = (r_op == OP_FILL) || (r_cx == r_ax) || (r_cx == r_ex)
                   || (r_cy == r_ay) || (r_cy == r_ey);
        prod     = (XW+DIM_W+1)'(py[YW-1:0]) * (XW+DIM_W+1)'(wd[DIM_W-1:0])
                   + (XW+DIM_W+1)'(px[XW-1:0]);
        we       = i_cmd.clr_step
                   || (i_cmd.rect_step && !r_rect_empty && border && in_frame)
                   || (i_cmd.line_step && r_steps != '0 && in_frame);
        waddr    = i_cmd.clr_step ? r_clr : prod[ADDR_W-1:0];
        wdata    = i_cmd.clr_step ? RESET_PIXEL : r_color;
        rd_out   = (r_ax < 0) || (r_ay < 0) || (r_ax >= wd) || (r_ay >= hd);
        raddr    = ADDR_W'((XW+DIM_W+1)'(r_ay[YW-1:0]) * (XW+DIM_W+1)'(wd[DIM_W-1:0])
                   + (XW+DIM_W+1)'(r_ax[XW-1:0]));
    end

    // Frame store
    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (i_cmd.rd) r_rdata <= mem[raddr];
    end

    // Sweep the store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)          r_clr <= '0;
        else if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
    end

    // Capture the command beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_opcode);
            r_color <= i_color;
            r_ax    <= t_crd'(i_ax);
            r_ay    <= t_crd'(i_ay);
            r_bx    <= t_crd'(i_bx);
            r_by    <= t_crd'(i_by);
        end
        if (i_cmd.setup1) begin
            r_sumx    <= r_ax + r_bx;
            r_sumy    <= r_ay + r_by;
            r_dx      <= r_bx - r_ax;
            r_dy      <= r_by - r_ay;
            r_outside <= rd_out;
        end
        if (i_cmd.setup2) begin
            r_rx0        <= rx0;
            r_cx         <= rx0;
            r_cy         <= ry0;
            r_rxl        <= rx1 - 1'b1;
            r_ryl        <= ry1 - 1'b1;
            r_ex         <= r_sumx - 1'b1;
            r_ey         <= r_sumy - 1'b1;
            r_rect_empty <= (r_bx <= 0) || (r_by <= 0) || (rx0 >= rx1) || (ry0 >= ry1);
            r_adx        <= adx[STP_W-1:0];
            r_ady        <= ady[STP_W-1:0];
            r_steps      <= (adx > ady) ? adx[STP_W-1:0] : ady[STP_W-1:0];
            r_stm1       <= ((adx > ady) ? adx[STP_W-1:0] : ady[STP_W-1:0]) - 1'b1;
            r_sx         <= r_dx < 0;
            r_sy         <= r_dy < 0;
            r_lx         <= r_ax;
            r_ly         <= r_ay;
            r_i          <= '0;
            r_accx       <= '0;
            r_accy       <= '0;
        end
        // Advance the rectangle walker
        if (i_cmd.rect_step) begin
            if (r_cx == r_rxl) begin
                r_cx <= r_rx0;
                r_cy <= r_cy + 1'b1;
            end else begin
                r_cx <= r_cx + 1'b1;
            end
        end
        // Advance the line walker by exact remainder tracking
        if (i_cmd.line_step) begin
            r_i <= r_i + 1'b1;
            if (sumax >= {1'b0, r_steps}) begin
                r_accx <= STP_W'(sumax - {1'b0, r_steps});
                r_lx   <= r_sx ? r_lx - 1'b1 : r_lx + 1'b1;
            end else begin
                r_accx <= sumax[STP_W-1:0];
            end
            if (sumay >= {1'b0, r_steps}) begin
                r_accy <= STP_W'(sumay - {1'b0, r_steps});
                r_ly   <= r_sy ? r_ly - 1'b1 : r_ly + 1'b1;
            end else begin
                r_accy <= sumay[STP_W-1:0];
            end
        end
    end

    // Status to the sequencer
    always_comb begin
        o_sts.op         = r_op;
        o_sts.clr_last   = (r_clr == '1);
        o_sts.rect_empty = r_rect_empty;
        o_sts.rect_last  = (r_cx == r_rxl) && (r_cy == r_ryl);
        o_sts.line_empty = (r_steps == '0);
        o_sts.line_last  = (r_i == r_stm1);
    end

    // Result beat
    assign o_read_outside = (r_op == OP_READ) && r_outside;
    assign o_pixel_value  = (r_op == OP_READ && !r_outside) ? r_rdata : 32'd0;

endmodule

// File: rtl/core/clipped_raster_draw_engine.sv
// Top level of the clipped raster draw engine.
// After reset the engine sweeps its 4096-pixel frame store to opaque black, one
// pixel a cycle, and holds busy high throughout the sweep. A command is taken
// when start is high and busy is low. Fill and outline walk every pixel of the
// clipped rectangle (outline walks the whole clipped box), a line walks its
// max(|dx|,|dy|) points and a read fetches one pixel. The single frame store
// write port takes one pixel a cycle. Each command yields one result beat on
// o_result_valid for exactly one cycle; the receiver cannot stall it. Write width
// and height only while busy is low and no result is due.
module clipped_raster_draw_engine import crde_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [DIM_W-1:0]   i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic [31:0]        i_color,
    input  logic signed [15:0] i_point_a_x,
    input  logic signed [15:0] i_point_a_y,
    input  logic signed [15:0] i_extent_or_end_x,
    input  logic signed [15:0] i_extent_or_end_y,
    output logic               o_result_valid,
    output logic [31:0]        o_pixel_value,
    output logic               o_read_outside
);

    logic [DIM_W-1:0] r_width, r_height;
    t_cmd             cmd;
    t_sts             sts;

    // Hold frame dimensions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(64);
            r_height <= DIM_W'(64);
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    crde_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_result_valid)
    );

    crde_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_w            (r_width),
        .i_h            (r_height),
        .i_opcode       (i_opcode),
        .i_color        (i_color),
        .i_ax           (i_point_a_x),
        .i_ay           (i_point_a_y),
        .i_bx           (i_extent_or_end_x),
        .i_by           (i_extent_or_end_y),
        .o_sts          (sts),
        .o_pixel_value  (o_pixel_value),
        .o_read_outside (o_read_outside)
    );

endmodule

// File: verif/clipped_raster_draw_engine_tb.sv
// Self-checking testbench for the clipped raster draw engine against a frame store model.
module clipped_raster_draw_engine_tb;
    import crde_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] pix;
        logic        outside;
    } t_read_beat;

    // Frame store model and the queue of read beats it predicts
    class frame_scoreboard;
        logic [31:0] pixels[MAX_WIDTH*MAX_HEIGHT];
        int          reg_w;
        int          reg_h;
        t_read_beat  due[$];
        int          errors;

        function new();
            foreach (pixels[i]) pixels[i] = RESET_PIXEL;
            reg_w  = 64;
            reg_h  = 64;
            errors = 0;
        endfunction

        function int frame_w();
            return (reg_w > MAX_WIDTH) ? MAX_WIDTH : reg_w;
        endfunction

        function int frame_h();
            return (reg_h > MAX_HEIGHT) ? MAX_HEIGHT : reg_h;
        endfunction

        function void set_reg(t_reg idx, int val);
            if (idx == REG_WIDTH) reg_w = val;
            else reg_h = val;
        endfunction

        function void plot(longint x, longint y, logic [31:0] c);
            if (x < 0 || y < 0 || x >= frame_w() || y >= frame_h()) return;
            pixels[y * frame_w() + x] = c;
        endfunction

        function void hspan(int y, int x0, int x1, logic [31:0] c);
            if (x0 < 0) x0 = 0;
            if (x1 > frame_w()) x1 = frame_w();
            for (int x = x0; x < x1; x++) plot(x, y, c);
        endfunction

        function void vspan(int x, int y0, int y1, logic [31:0] c);
            if (y0 < 0) y0 = 0;
            if (y1 > frame_h()) y1 = frame_h();
            for (int y = y0; y < y1; y++) plot(x, y, c);
        endfunction

        // Apply one accepted command to the model and queue its beat
        function void note_command(t_op op, logic [31:0] c, int ax, int ay, int bx, int by);
            t_read_beat b;
            longint dx, dy, steps;
            int y1;
            b.pix     = '0;
            b.outside = 1'b0;
            case (op)
                OP_FILL: begin
                    y1 = ay + by;
                    if (y1 > frame_h()) y1 = frame_h();
                    for (int y = (ay < 0) ? 0 : ay; y < y1; y++) hspan(y, ax, ax + bx, c);
                end
                OP_OUTLINE: begin
                    if (bx > 0 && by > 0) begin
                        hspan(ay, ax, ax + bx, c);
                        hspan(ay + by - 1, ax, ax + bx, c);
                        vspan(ax, ay, ay + by, c);
                        vspan(ax + bx - 1, ay, ay + by, c);
                    end
                end
                OP_LINE: begin
                    dx    = longint'(bx) - ax;
                    dy    = longint'(by) - ay;
                    steps = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy)
                            ? ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy);
                    for (longint i = 0; i < steps; i++)
                        plot(ax + (dx * i) / steps, ay + (dy * i) / steps, c);
                end
                default: begin
                    if (ax < 0 || ay < 0 || ax >= frame_w() || ay >= frame_h())
                        b.outside = 1'b1;
                    else
                        b.pix = pixels[ay * frame_w() + ax];
                end
            endcase
            due.push_back(b);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Compare one result beat with the oldest prediction
        task check_beat(logic [31:0] pix, logic outside);
            t_read_beat b;
            if (due.size() == 0) begin
                report_mismatch("result beat with nothing due");
                return;
            end
            b = due.pop_front();
            if (pix !== b.pix)
                report_mismatch($sformatf("pixel_value %h, want %h", pix, b.pix));
            if (outside !== b.outside)
                report_mismatch($sformatf("read_outside %b, want %b", outside, b.outside));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [DIM_W-1:0]   i_cfg_data;
    logic               start;
    logic               busy;
    logic [1:0]         i_opcode;
    logic [31:0]        i_color;
    logic signed [15:0] i_point_a_x;
    logic signed [15:0] i_point_a_y;
    logic signed [15:0] i_extent_or_end_x;
    logic signed [15:0] i_extent_or_end_y;
    logic               o_result_valid;
    logic [31:0]        o_pixel_value;
    logic               o_read_outside;

    frame_scoreboard sb = new();
    bit              gaps_on;

    clipped_raster_draw_engine dut (.*);

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Note accepted commands and check result beats on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) sb.check_beat(o_pixel_value, o_read_outside);
            if (start && !busy)
                sb.note_command(t_op'(i_opcode), i_color, i_point_a_x, i_point_a_y,
                                i_extent_or_end_x, i_extent_or_end_y);
        end
    end

    // Keep start low until busy is low, then present one command beat
    task issue(t_op op, logic [31:0] c, int ax, int ay, int bx, int by);
        while (gaps_on && $urandom_range(99) < 29) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        while (busy) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        i_opcode          = op;
        i_color           = c;
        i_point_a_x       = 16'(ax);
        i_point_a_y       = 16'(ay);
        i_extent_or_end_x = 16'(bx);
        i_extent_or_end_y = 16'(by);
        start             = 1'b1;
        @(negedge i_clk);
    endtask

    // Drop start and wait until every predicted beat has arrived
    task drain();
        start = 1'b0;
        while (sb.due.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task write_reg(t_reg idx, int val);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = DIM_W'(val);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    function int near_coord();
        return $urandom_range(84) - 10;
    endfunction

    function int wide_coord();
        return int'($signed(16'($urandom())));
    endfunction

    // One random command: mostly near the frame, sometimes anywhere
    task random_command();
        t_op op;
        bit  wide;
        int  ax, ay, bx, by;
        op   = t_op'($urandom_range(3));
        wide = ($urandom_range(99) < 8);
        ax   = wide ? wide_coord() : near_coord();
        ay   = wide ? wide_coord() : near_coord();
        if (op == OP_LINE) begin
            // rare long lines, as the engine walks a line one step at a time
            if ($urandom_range(199) == 0) begin
                bx = wide_coord();
                by = wide_coord();
            end else begin
                ax = near_coord();
                ay = near_coord();
                bx = near_coord();
                by = near_coord();
            end
        end else if (op == OP_READ) begin
            bx = wide_coord();
            by = wide_coord();
        end else begin
            bx = wide ? wide_coord() : $urandom_range(30) - 4;
            by = wide ? wide_coord() : $urandom_range(30) - 4;
        end
        issue(op, $urandom(), ax, ay, bx, by);
    endtask

    initial begin
        int widths[7]  = '{64, 1, 0, 127, 37, 64, 5};
        int heights[7] = '{64, 1, 64, 127, 20, 0, 64};
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_WIDTH;
        i_cfg_data = '0;
        start      = 1'b0;
        i_opcode   = OP_READ;
        i_color    = '0;
        i_point_a_x       = '0;
        i_point_a_y       = '0;
        i_extent_or_end_x = '0;
        i_extent_or_end_y = '0;
        gaps_on    = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, each operation, empty and clipped shapes
        issue(OP_READ, '0, 0, 0, 0, 0);
        issue(OP_READ, '0, 63, 63, 0, 0);
        issue(OP_FILL, 32'hFFFF_FFFF, -32768, -32768, 32767, 32767);
        issue(OP_READ, '0, 10, 20, 0, 0);
        issue(OP_FILL, 32'h0000_0000, 2, 3, 4, 5);
        issue(OP_FILL, 32'h1234_5678, 5, 5, 0, 6);
        issue(OP_FILL, 32'h1234_5678, 5, 5, -3, 6);
        issue(OP_OUTLINE, 32'hA5A5_5A5A, 10, 10, 8, 6);
        issue(OP_OUTLINE, 32'h5A5A_A5A5, 60, -2, 10, 10);
        issue(OP_OUTLINE, 32'h0F0F_F0F0, 20, 20, 0, 5);
        issue(OP_OUTLINE, 32'h0F0F_F0F0, 20, 20, 1, 1);
        issue(OP_LINE, 32'hDEAD_BEEF, 0, 0, 63, 20);
        issue(OP_LINE, 32'hCAFE_F00D, 63, 0, 0, 63);
        issue(OP_LINE, 32'h1111_2222, 30, 30, 30, 30);
        issue(OP_LINE, 32'h3333_4444, -20, 40, 80, 10);
        issue(OP_LINE, 32'h5555_6666, 32767, -32768, -32768, 32767);
        issue(OP_READ, '0, 11, 10, 0, 0);
        issue(OP_READ, '0, 2, 3, 0, 0);
        issue(OP_READ, '0, 64, 0, 0, 0);
        issue(OP_READ, '0, 0, 64, 0, 0);
        issue(OP_READ, '0, -1, 5, 0, 0);
        issue(OP_READ, '0, 32767, -32768, -1, -1);
        issue(OP_READ, '0, 20, 20, 0, 0);

        // Random phases under several frame sizes, extremes included
        for (int p = 0; p < 7; p++) begin
            write_reg(REG_WIDTH, widths[p]);
            write_reg(REG_HEIGHT, heights[p]);
            gaps_on = (p != 3);
            for (int n = 0; n < 100; n++) begin
                random_command();
                if (p == 4 && n == 50) drain();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("[clipped_raster_draw_engine] OK");
        else
            $display("[clipped_raster_draw_engine] ERROR");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("[clipped_raster_draw_engine] ERROR");
        $finish;
    end
endmodule
